[src/spi_slave_command_framer_unit_assert.svh]
// Assertion macros used by the framer checker
`ifndef SPI_SLAVE_COMMAND_FRAMER_UNIT_ASSERT_SVH
`define SPI_SLAVE_COMMAND_FRAMER_UNIT_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent
`define SSCF_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define SSCF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[src/sscf_pkg.sv]
// Shared types, constants and functions of the SPI slave command framer
`timescale 1ns / 1ps
`default_nettype none
package sscf_pkg;

	localparam int BUFFER_BYTES = 11;
	localparam int IDX_W = $clog2(BUFFER_BYTES + 1);
	localparam int BUF_AW = $clog2(BUFFER_BYTES);
	localparam int LEN_W = 4;

	localparam logic [7:0] MAX_COMMAND = 8'd6;
	localparam logic [7:0] ANSWER_BUSY = 8'hFD;
	localparam logic [7:0] ANSWER_ERROR = 8'hFE;
	localparam logic [7:0] SEQ_RESET = 8'hA5;
	localparam logic [15:0] CRC_SEED_RESET = 16'hA55A;

	// Input command codes
	localparam logic [2:0] CMD_SPI_BYTE = 3'd0;
	localparam logic [2:0] CMD_CS_RELEASE = 3'd1;
	localparam logic [2:0] CMD_HOST_READ = 3'd2;
	localparam logic [2:0] CMD_HOST_WRITE = 3'd3;
	localparam logic [2:0] CMD_COMMIT = 3'd4;

	// Link states as seen on frame_state
	typedef enum logic [1:0] {
		LS_RECEIVING = 2'd0,
		LS_TRANSMITTING = 2'd1,
		LS_ERROR = 2'd2,
		LS_AWAITING = 2'd3
	} link_state_t;

	typedef struct packed {
		logic [2:0] cmd;
		logic [7:0] rx_byte;
		logic [3:0] buf_pos;
		logic [7:0] buf_value;
	} in_item_t;

	typedef struct packed {
		logic [7:0] tx_byte;
		logic tx_load;
		logic command_ready;
		logic [2:0] command_id;
		logic [1:0] frame_state;
		logic [7:0] buffer_data;
	} out_item_t;

	// Datapath operations issued by the controller
	typedef enum logic [4:0] {
		OP_NONE = 5'd0,
		OP_LATCH = 5'd1,
		OP_SPI = 5'd2,
		OP_SPI_TX = 5'd3,
		OP_REQ_SEED = 5'd4,
		OP_REQ_STEP = 5'd5,
		OP_CMP_LO = 5'd6,
		OP_CMP_HI = 5'd7,
		OP_RESTART = 5'd8,
		OP_HREAD = 5'd9,
		OP_HWRITE = 5'd10,
		OP_RESP_SEED = 5'd11,
		OP_RESP_STEP = 5'd12,
		OP_STORE_LO = 5'd13,
		OP_STORE_HI = 5'd14,
		OP_COMMIT_TX = 5'd15,
		OP_PUBLISH = 5'd16
	} dp_op_t;

	typedef struct packed {
		dp_op_t op;
	} dp_ctrl_t;

	typedef struct packed {
		logic spi_fatal;
		logic spi_check;
		logic req_more;
		logic resp_more;
		logic awaiting;
	} dp_status_t;

	// One byte of reflected CCITT (poly 0x8408)
	function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] b);
		logic [7:0] d;
		logic [7:0] e;
		d = b ^ crc[7:0];
		e = d ^ {d[3:0], 4'b0000};
		return {e, crc[15:8]} ^ {12'b0, e[7:4]} ^ {5'b0, e, 3'b000};
	endfunction

	// Request length per command id
	function automatic logic [LEN_W-1:0] req_len_of(input logic [2:0] id);
		logic [LEN_W-1:0] len;
		case (id)
			3'd0: len = LEN_W'(4);
			3'd1: len = LEN_W'(8);
			3'd2: len = LEN_W'(7);
			3'd3: len = LEN_W'(3);
			3'd4: len = LEN_W'(4);
			3'd5: len = LEN_W'(3);
			3'd6: len = LEN_W'(6);
			default: len = '0;
		endcase
		return len;
	endfunction

	// Whole frame length per command id
	function automatic logic [LEN_W-1:0] frame_len_of(input logic [2:0] id);
		logic [LEN_W-1:0] len;
		case (id)
			3'd0: len = LEN_W'(10);
			3'd1: len = LEN_W'(10);
			3'd2: len = LEN_W'(9);
			3'd3: len = LEN_W'(6);
			3'd4: len = LEN_W'(6);
			3'd5: len = LEN_W'(7);
			3'd6: len = LEN_W'(11);
			default: len = '0;
		endcase
		return len;
	endfunction

endpackage
`default_nettype wire

[src/sscf_ctrl.sv]
// Controller state machine of the SPI slave command framer
`timescale 1ns / 1ps
`default_nettype none
module sscf_ctrl (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	input wire logic [2:0] in_cmd,
	output logic in_stall,
	output logic out_valid,
	input wire logic out_stall,
	input wire sscf_pkg::dp_status_t stat,
	output sscf_pkg::dp_ctrl_t ctrl
);
	import sscf_pkg::*;

	typedef enum logic [15:0] {
		S_IDLE = 16'b0000_0000_0000_0001,
		S_SPI = 16'b0000_0000_0000_0010,
		S_SPI_TX = 16'b0000_0000_0000_0100,
		S_REQ_SEED = 16'b0000_0000_0000_1000,
		S_REQ_STEP = 16'b0000_0000_0001_0000,
		S_CMP_LO = 16'b0000_0000_0010_0000,
		S_CMP_HI = 16'b0000_0000_0100_0000,
		S_RESTART = 16'b0000_0000_1000_0000,
		S_HREAD = 16'b0000_0001_0000_0000,
		S_HWRITE = 16'b0000_0010_0000_0000,
		S_RESP_SEED = 16'b0000_0100_0000_0000,
		S_RESP_STEP = 16'b0000_1000_0000_0000,
		S_STORE_LO = 16'b0001_0000_0000_0000,
		S_STORE_HI = 16'b0010_0000_0000_0000,
		S_COMMIT_TX = 16'b0100_0000_0000_0000,
		S_RESULT = 16'b1000_0000_0000_0000
	} state_t;

	state_t state_q;
	state_t state_nx;
	logic out_valid_q;
	logic out_free;

	assign in_stall = (state_q != S_IDLE);
	assign out_valid = out_valid_q;
	assign out_free = !out_valid_q || !out_stall;

	// Sequence the datapath one operation per cycle; the result state waits while the output is stalled
	always_comb begin
		state_nx = state_q;
		ctrl.op = OP_NONE;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					ctrl.op = OP_LATCH;
					case (in_cmd)
						CMD_SPI_BYTE: state_nx = S_SPI;
						CMD_CS_RELEASE: state_nx = S_RESTART;
						CMD_HOST_READ: state_nx = S_HREAD;
						CMD_HOST_WRITE: state_nx = S_HWRITE;
						CMD_COMMIT: state_nx = stat.awaiting ? S_RESP_SEED : S_RESULT;
						default: state_nx = S_RESULT;
					endcase
				end
			end
			S_SPI: begin
				ctrl.op = OP_SPI;
				if (stat.spi_fatal)
					state_nx = S_RESULT;
				else if (stat.spi_check)
					state_nx = S_REQ_SEED;
				else
					state_nx = S_SPI_TX;
			end
			S_SPI_TX: begin
				ctrl.op = OP_SPI_TX;
				state_nx = S_RESULT;
			end
			S_REQ_SEED: begin
				ctrl.op = OP_REQ_SEED;
				state_nx = S_REQ_STEP;
			end
			S_REQ_STEP: begin
				ctrl.op = OP_REQ_STEP;
				if (!stat.req_more)
					state_nx = S_CMP_LO;
			end
			S_CMP_LO: begin
				ctrl.op = OP_CMP_LO;
				state_nx = S_CMP_HI;
			end
			S_CMP_HI: begin
				ctrl.op = OP_CMP_HI;
				state_nx = S_RESULT;
			end
			S_RESTART: begin
				ctrl.op = OP_RESTART;
				state_nx = S_RESULT;
			end
			S_HREAD: begin
				ctrl.op = OP_HREAD;
				state_nx = S_RESULT;
			end
			S_HWRITE: begin
				ctrl.op = OP_HWRITE;
				state_nx = S_RESULT;
			end
			S_RESP_SEED: begin
				ctrl.op = OP_RESP_SEED;
				state_nx = S_RESP_STEP;
			end
			S_RESP_STEP: begin
				ctrl.op = OP_RESP_STEP;
				if (!stat.resp_more)
					state_nx = S_STORE_LO;
			end
			S_STORE_LO: begin
				ctrl.op = OP_STORE_LO;
				state_nx = S_STORE_HI;
			end
			S_STORE_HI: begin
				ctrl.op = OP_STORE_HI;
				state_nx = S_COMMIT_TX;
			end
			S_COMMIT_TX: begin
				ctrl.op = OP_COMMIT_TX;
				state_nx = S_RESULT;
			end
			S_RESULT: begin
				if (out_free) begin
					ctrl.op = OP_PUBLISH;
					state_nx = S_IDLE;
				end
			end
			default: state_nx = S_IDLE;
		endcase
	end

	// Advance state; hold the output word until it is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (ctrl.op == OP_PUBLISH)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

endmodule
`default_nettype wire

[src/sscf_datapath.sv]
// Datapath of the SPI slave command framer: frame buffer, CRC unit, link registers
`timescale 1ns / 1ps
`default_nettype none
module sscf_datapath (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_wr_en,
	input wire logic [15:0] cfg_wr_data,
	input wire sscf_pkg::in_item_t in_data,
	input wire sscf_pkg::dp_ctrl_t ctrl,
	output sscf_pkg::dp_status_t stat,
	output sscf_pkg::out_item_t out_data
);
	import sscf_pkg::*;

	// Link state
	logic [15:0] crc_seed_q;
	logic [7:0] buf_q [BUFFER_BYTES];
	logic [IDX_W-1:0] byte_index_q;
	link_state_t link_state_q;
	logic [7:0] seq_q;
	logic [LEN_W-1:0] req_len_q;
	logic [LEN_W-1:0] frame_len_q;
	logic [2:0] active_id_q;

	// Working registers
	logic [15:0] crc_q;
	logic [IDX_W-1:0] walk_idx_q;
	logic lo_ok_q;
	in_item_t item_q;
	logic [7:0] res_tx_q;
	logic res_load_q;
	logic [7:0] res_rdata_q;
	out_item_t out_q;

	// Buffer ports
	logic [IDX_W-1:0] rd_addr;
	logic [7:0] rd_data;
	logic wr_en;
	logic [IDX_W-1:0] wr_addr;
	logic [7:0] wr_data;

	// Decode of an incoming spi byte
	logic spi_fatal;
	logic spi_first;
	logic [IDX_W-1:0] bi_next;
	logic [7:0] id_byte;
	logic id_ok;
	logic [LEN_W-1:0] req_len_new;
	logic spi_check;
	logic req_more;
	logic resp_more;
	logic fl_ok;
	logic [IDX_W-1:0] fl_m2;
	logic [IDX_W-1:0] fl_m1;
	logic crc_hi_ok;

	assign spi_fatal = (byte_index_q >= IDX_W'(BUFFER_BYTES))
		|| (link_state_q == LS_ERROR) || (link_state_q == LS_AWAITING);
	assign spi_first = (byte_index_q == '0);
	assign bi_next = byte_index_q + IDX_W'(1);
	assign id_byte = (spi_first && link_state_q == LS_RECEIVING) ? item_q.rx_byte : buf_q[0];
	assign id_ok = (id_byte <= MAX_COMMAND);
	assign req_len_new = (spi_first && id_ok) ? req_len_of(id_byte[2:0]) : req_len_q;
	assign spi_check = !(spi_first && !id_ok) && (bi_next == IDX_W'(req_len_new));

	assign req_more = (walk_idx_q < IDX_W'(req_len_q));
	assign resp_more = (({1'b0, walk_idx_q} + (IDX_W + 1)'(2)) < (IDX_W + 1)'(frame_len_q));
	assign fl_ok = (frame_len_q >= LEN_W'(2))
		&& (IDX_W'(frame_len_q) <= IDX_W'(BUFFER_BYTES));
	assign fl_m2 = IDX_W'(frame_len_q) - IDX_W'(2);
	assign fl_m1 = IDX_W'(frame_len_q) - IDX_W'(1);
	assign crc_hi_ok = lo_ok_q && (rd_data == crc_q[15:8]);

	assign stat.spi_fatal = spi_fatal;
	assign stat.spi_check = spi_check;
	assign stat.req_more = req_more;
	assign stat.resp_more = resp_more;
	assign stat.awaiting = (link_state_q == LS_AWAITING);

	assign out_data = out_q;

	// Select the address of the buffer read port; beyond the buffer it reads zero
	always_comb begin
		case (ctrl.op)
			OP_REQ_STEP: rd_addr = walk_idx_q;
			OP_CMP_LO: rd_addr = IDX_W'(1);
			OP_CMP_HI: rd_addr = IDX_W'(2);
			OP_HREAD: rd_addr = IDX_W'(item_q.buf_pos);
			OP_SPI_TX: rd_addr = byte_index_q;
			OP_COMMIT_TX: rd_addr = byte_index_q;
			default: rd_addr = '0;
		endcase
	end
	assign rd_data = (rd_addr < IDX_W'(BUFFER_BYTES)) ? buf_q[rd_addr[BUF_AW-1:0]] : 8'h00;

	// Select the single buffer write
	always_comb begin
		wr_en = 1'b0;
		wr_addr = byte_index_q;
		wr_data = item_q.rx_byte;
		case (ctrl.op)
			OP_SPI: begin
				wr_en = !spi_fatal && (link_state_q == LS_RECEIVING);
			end
			OP_HWRITE: begin
				wr_en = 1'b1;
				wr_addr = IDX_W'(item_q.buf_pos);
				wr_data = item_q.buf_value;
			end
			OP_STORE_LO: begin
				wr_en = fl_ok;
				wr_addr = fl_m2;
				wr_data = crc_q[7:0];
			end
			OP_STORE_HI: begin
				wr_en = fl_ok;
				wr_addr = fl_m1;
				wr_data = crc_q[15:8];
			end
			default: wr_en = 1'b0;
		endcase
	end

	// Frame buffer, cleared at reset; drop writes beyond the buffer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < BUFFER_BYTES; i++)
				buf_q[i] <= 8'h00;
		end else if (wr_en && (wr_addr < IDX_W'(BUFFER_BYTES))) begin
			buf_q[wr_addr[BUF_AW-1:0]] <= wr_data;
		end
	end

	// Link state and seed register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_seed_q <= CRC_SEED_RESET;
			byte_index_q <= '0;
			link_state_q <= LS_RECEIVING;
			seq_q <= SEQ_RESET;
			req_len_q <= '0;
			frame_len_q <= '0;
			active_id_q <= '0;
		end else begin
			if (cfg_wr_en)
				crc_seed_q <= cfg_wr_data;
			case (ctrl.op)
				OP_SPI: begin
					if (spi_fatal) begin
						link_state_q <= LS_ERROR;
					end else begin
						byte_index_q <= bi_next;
						if (spi_first) begin
							if (id_ok) begin
								active_id_q <= id_byte[2:0];
								req_len_q <= req_len_of(id_byte[2:0]);
								frame_len_q <= frame_len_of(id_byte[2:0]);
							end else begin
								link_state_q <= LS_ERROR;
							end
						end
					end
				end
				OP_SPI_TX: begin
					if (link_state_q == LS_TRANSMITTING
						&& byte_index_q == IDX_W'(frame_len_q)) begin
						byte_index_q <= '0;
						link_state_q <= LS_RECEIVING;
					end
				end
				OP_CMP_HI: begin
					if (crc_hi_ok) begin
						seq_q <= seq_q + 8'd1;
						link_state_q <= LS_AWAITING;
					end else begin
						link_state_q <= LS_ERROR;
					end
				end
				OP_RESTART: begin
					byte_index_q <= '0;
					link_state_q <= LS_RECEIVING;
				end
				OP_COMMIT_TX: link_state_q <= LS_TRANSMITTING;
				default: ;
			endcase
		end
	end

	// CRC walk, staged item and result word
	always_ff @(posedge clk) begin
		case (ctrl.op)
			OP_LATCH: begin
				item_q <= in_data;
				res_tx_q <= 8'h00;
				res_load_q <= 1'b0;
				res_rdata_q <= 8'h00;
			end
			OP_SPI: begin
				res_load_q <= 1'b1;
				res_tx_q <= spi_fatal ? ANSWER_ERROR : ANSWER_BUSY;
			end
			OP_SPI_TX: begin
				if (link_state_q == LS_TRANSMITTING) begin
					if (byte_index_q == IDX_W'(frame_len_q))
						res_tx_q <= seq_q;
					else
						res_tx_q <= rd_data;
				end
			end
			OP_REQ_SEED: begin
				crc_q <= crc_step(crc_seed_q, buf_q[0]);
				walk_idx_q <= IDX_W'(3);
			end
			OP_REQ_STEP: begin
				if (req_more) begin
					crc_q <= crc_step(crc_q, rd_data);
					walk_idx_q <= walk_idx_q + IDX_W'(1);
				end
			end
			OP_CMP_LO: lo_ok_q <= (rd_data == crc_q[7:0]);
			OP_CMP_HI: begin
				if (crc_hi_ok) begin
					res_tx_q <= 8'h00;
					res_load_q <= 1'b0;
				end
			end
			OP_RESTART: begin
				res_tx_q <= seq_q;
				res_load_q <= 1'b1;
			end
			OP_HREAD: res_rdata_q <= rd_data;
			OP_RESP_SEED: begin
				crc_q <= crc_seed_q;
				walk_idx_q <= IDX_W'(req_len_q);
			end
			OP_RESP_STEP: begin
				if (resp_more) begin
					crc_q <= crc_step(crc_q, rd_data_walk(walk_idx_q));
					walk_idx_q <= walk_idx_q + IDX_W'(1);
				end
			end
			OP_COMMIT_TX: begin
				res_tx_q <= rd_data;
				res_load_q <= 1'b1;
			end
			OP_PUBLISH: begin
				out_q.tx_byte <= res_tx_q;
				out_q.tx_load <= res_load_q;
				out_q.command_ready <= (link_state_q == LS_AWAITING);
				out_q.command_id <= active_id_q;
				out_q.frame_state <= link_state_q;
				out_q.buffer_data <= res_rdata_q;
			end
			default: ;
		endcase
	end

	// Buffer byte at the response walk position; beyond the buffer reads zero
	function automatic logic [7:0] rd_data_walk(input logic [IDX_W-1:0] idx);
		return (idx < IDX_W'(BUFFER_BYTES)) ? buf_q[idx[BUF_AW-1:0]] : 8'h00;
	endfunction

endmodule
`default_nettype wire

[src/spi_slave_command_framer_unit.sv]
// Top level of the SPI slave command framer
// Flow: an ignored commit or unused command goes straight to the result; host access, chip
// select release and spi bytes run their operation first; a closing request byte walks and
// checks the request CRC, a commit walks the response CRC and stores it before transmitting.
// Throughput: one word at a time; the byte-serial CRC walk and output stalls set the pace.
// Reset: arst_n clears the frame buffer, link state, sequence number (0xA5) and seed (0xA55A).
`timescale 1ns / 1ps
`default_nettype none
module spi_slave_command_framer_unit (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_wr_en,
	input wire logic [15:0] cfg_wr_data,
	input wire logic in_valid,
	output logic in_stall,
	input wire sscf_pkg::in_item_t in_data,
	output logic out_valid,
	input wire logic out_stall,
	output sscf_pkg::out_item_t out_data
);
	import sscf_pkg::*;

	dp_ctrl_t ctrl;
	dp_status_t stat;

	// Sequence the work
	sscf_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_cmd(in_data.cmd),
		.in_stall(in_stall),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.stat(stat),
		.ctrl(ctrl)
	);

	// Hold buffer, state and CRC
	sscf_datapath u_datapath (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.in_data(in_data),
		.ctrl(ctrl),
		.stat(stat),
		.out_data(out_data)
	);

endmodule
`default_nettype wire

[src/sscf_checker.sv]
// Port-level checker of the SPI slave command framer and its bind
`timescale 1ns / 1ps
`default_nettype none
`include "spi_slave_command_framer_unit_assert.svh"
module sscf_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	input wire logic in_stall,
	input wire sscf_pkg::in_item_t in_data,
	input wire logic out_valid,
	input wire logic out_stall,
	input wire sscf_pkg::out_item_t out_data
);
	import sscf_pkg::*;

	// A stalled output word holds
	`SSCF_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(out_data), "stalled output word changed")

	// One word in work at a time
	`SSCF_ASSERT_NEXT(a_one_at_a_time, clk, arst_n, in_valid && !in_stall, in_stall, "input taken while a word is in work")

	// No load means a zero answer byte
	`SSCF_ASSERT_SAME(a_tx_zero, clk, arst_n, out_valid && !out_data.tx_load, out_data.tx_byte == 8'h00, "tx_byte set without tx_load")

	// Ready flag tracks the awaiting state
	`SSCF_ASSERT_SAME(a_ready_state, clk, arst_n, out_valid, out_data.command_ready == (out_data.frame_state == LS_AWAITING), "command_ready disagrees with frame_state")

	// Read data never comes with a shifter load
	`SSCF_ASSERT_SAME(a_read_no_load, clk, arst_n, out_valid && (out_data.buffer_data != 8'h00), !out_data.tx_load, "read data with tx_load")

endmodule

bind spi_slave_command_framer_unit sscf_checker u_sscf_checker (.*);
`default_nettype wire
